@@ hw/rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and helper functions of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned DW         = 2 * WORD_WIDTH;   // doubled format
  localparam int unsigned QBITS      = DW - 1;           // quotient bits
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned FRAC_W     = 5;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned SH_W       = 7;                // shift amount over DW
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [DW-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] REG_WORD_LENGTH   = 2'd0;
  localparam logic [1:0] REG_FRAC_BITS     = 2'd1;
  localparam logic [1:0] REG_OUT_LENGTH    = 2'd2;
  localparam logic [1:0] REG_OUT_FRAC_BITS = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_CVT = 3'd5
  } op_e;

  // clamped format settings
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [FRAC_W-1:0] f;
    logic [LEN_W-1:0]  nlen;
    logic [FRAC_W-1:0] nf;
  } cfg_t;

  // result and flags of the execute stage, rides along the divider
  typedef struct packed {
    logic [DW-1:0] res;
    logic          ovf;
    logic          lt;
    logic          eq;
    logic          dz;
    logic [OP_W-1:0] op;
  } side_t;

  // divider working set
  typedef struct packed {
    logic [QBITS-1:0]      nq;    // dividend bits in, quotient bits out
    logic [WORD_WIDTH-1:0] rem;
    logic [WORD_WIDTH-1:0] dvs;
    logic                  qneg;
  } div_t;

  // sign-extend x from bit w-1
  function automatic logic [DW-1:0] sext64(input logic [DW-1:0] x,
                                           input logic [LEN_W-1:0] w);
    logic [SH_W-1:0] sh;
    sh = SH_W'(DW) - SH_W'(w);
    return DW'($signed(x << sh) >>> sh);
  endfunction

endpackage

@@ hw/rtl/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: add, sub, mul, div, compare, format convert.
// Pipeline: 2 front stages, 63 divider stages and 1 output register,
//   the same path for every opcode.
// Throughput: one item per cycle; the whole pipeline holds on output stall.
// Reset: asynchronous active low; clears valid bits, formats to Q16.16.
// ----------------------------------------------------------------------------
module fixed_point_alu import fpa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op, operand_a, operand_b
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // result, overflow, less, equal, div_zero
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [LEN_W-1:0]       cfg_wdata_i
);

  logic [LEN_W-1:0]  word_length_q, out_length_q;
  logic [FRAC_W-1:0] frac_bits_q, out_frac_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_length_q   <= LEN_W'(32);
      frac_bits_q     <= FRAC_W'(16);
      out_length_q    <= LEN_W'(32);
      out_frac_bits_q <= FRAC_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WORD_LENGTH:   word_length_q   <= cfg_wdata_i;
        REG_FRAC_BITS:     frac_bits_q     <= cfg_wdata_i[FRAC_W-1:0];
        REG_OUT_LENGTH:    out_length_q    <= cfg_wdata_i;
        REG_OUT_FRAC_BITS: out_frac_bits_q <= cfg_wdata_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    if (v < LEN_W'(2))               return LEN_W'(2);
    else if (v > LEN_W'(WORD_WIDTH)) return LEN_W'(WORD_WIDTH);
    else                             return v;
  endfunction

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] v,
                                                   input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] top;
    top = len - 1'b1;
    return (LEN_W'(v) > top) ? top[FRAC_W-1:0] : v;
  endfunction

  cfg_t cfg;
  always_comb begin
    cfg.len  = clamp_len(word_length_q);
    cfg.f    = clamp_frac(frac_bits_q, cfg.len);
    cfg.nlen = clamp_len(out_length_q);
    cfg.nf   = clamp_frac(out_frac_bits_q, cfg.nlen);
  end

  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  logic  fr_valid, dv_valid;
  side_t fr_side, dv_side;
  div_t  fr_div, dv_div;

  fpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ce_i        (ce),
    .valid_i     (s_axis_tvalid),
    .op_i        (s_axis_tdata[OP_W-1:0]),
    .operand_a_i (s_axis_tdata[OP_W +: WORD_WIDTH]),
    .operand_b_i (s_axis_tdata[OP_W+WORD_WIDTH +: WORD_WIDTH]),
    .cfg_i       (cfg),
    .valid_o     (fr_valid),
    .side_o      (fr_side),
    .div_o       (fr_div)
  );

  fpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .div_i   (fr_div),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .div_o   (dv_div)
  );

  // output stage: sign-correct the quotient and pick the result
  logic [DW-1:0]          q, res;
  logic [OUT_TDATA_W-1:0] tdata_d;

  assign q   = DW'(dv_div.nq);
  assign res = (op_e'(dv_side.op) == OP_DIV && !dv_side.dz)
               ? (dv_div.qneg ? (~q + 1'b1) : q) : dv_side.res;
  assign tdata_d = OUT_TDATA_W'({dv_side.dz, dv_side.eq, dv_side.lt, dv_side.ovf, res});

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ce) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_tdata_q <= tdata_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;

endmodule

@@ hw/rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Operand prep stage and execute stage: add/sub, compare, convert,
// multiply, and divider setup.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ce_i,
  input  logic                  valid_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [WORD_WIDTH-1:0] operand_a_i,
  input  logic [WORD_WIDTH-1:0] operand_b_i,
  input  cfg_t                  cfg_i,
  output logic                  valid_o,
  output side_t                 side_o,
  output div_t                  div_o
);

  // stage 1: operands reduced and sign-extended
  logic                  s1_valid_q;
  logic [OP_W-1:0]       s1_op_q;
  logic [WORD_WIDTH-1:0] s1_a_q, s1_b_q;
  logic [DW-1:0]         a_ext, b_ext;

  assign a_ext = sext64(DW'(operand_a_i), cfg_i.len);
  assign b_ext = sext64(DW'(operand_b_i), cfg_i.len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ce_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      s1_op_q <= op_i;
      s1_a_q  <= a_ext[WORD_WIDTH-1:0];
      s1_b_q  <= b_ext[WORD_WIDTH-1:0];
    end
  end

  function automatic logic [DW-1:0] requant(input logic [DW-1:0] a,
                                            input cfg_t c);
    logic [DW-1:0]     fr, ip;
    logic [LEN_W-1:0]  cur_int, new_int;
    fr = a & ~(ALL_ONES << c.f);
    ip = DW'($signed(a) >>> c.f);
    if (c.f > c.nf) fr = fr >> (c.f - c.nf);
    else            fr = fr << (c.nf - c.f);
    cur_int = c.len - LEN_W'(c.f);
    new_int = c.nlen - LEN_W'(c.nf);
    if (new_int < cur_int) begin
      if (a[DW-1]) ip = ip | (ALL_ONES << new_int);
      else         ip = ip & ~(ALL_ONES << new_int);
    end
    return (ip << c.nf) | fr;
  endfunction

  // stage 2: execute
  logic [DW-1:0]         a64, b64, sum, dif, r, prod;
  logic [WORD_WIDTH-1:0] ma, mb;
  logic                  sa, sb, sr;
  side_t                 side_d;
  div_t                  div_d;
  logic [LEN_W-1:0]      sidx;

  assign a64  = DW'($signed(s1_a_q));
  assign b64  = DW'($signed(s1_b_q));
  assign sum  = a64 + b64;
  assign dif  = a64 - b64;
  assign prod = DW'($signed(s1_a_q) * $signed(s1_b_q));
  assign ma   = s1_a_q[WORD_WIDTH-1] ? (~s1_a_q + 1'b1) : s1_a_q;
  assign mb   = s1_b_q[WORD_WIDTH-1] ? (~s1_b_q + 1'b1) : s1_b_q;
  assign sidx = cfg_i.len - 1'b1;
  assign r    = (op_e'(s1_op_q) == OP_ADD) ? sum : dif;
  assign sa   = a64[sidx];
  assign sb   = b64[sidx];
  assign sr   = r[sidx];

  always_comb begin
    side_d     = '0;
    side_d.op  = s1_op_q;
    div_d.nq   = QBITS'(DW'(ma) << cfg_i.f);
    div_d.rem  = '0;
    div_d.dvs  = mb;
    div_d.qneg = s1_a_q[WORD_WIDTH-1] ^ s1_b_q[WORD_WIDTH-1];
    unique case (op_e'(s1_op_q))
      OP_ADD: begin
        side_d.ovf = (sa == sb) && (sr != sa);
        side_d.res = sext64(r, cfg_i.len);
      end
      OP_SUB: begin
        side_d.ovf = (sa != sb) && (sr != sa);
        side_d.res = sext64(r, cfg_i.len);
      end
      OP_MUL: side_d.res = prod;
      OP_DIV: side_d.dz = (s1_b_q == '0);
      OP_CMP: begin
        side_d.lt = $signed(s1_a_q) < $signed(s1_b_q);
        side_d.eq = (s1_a_q == s1_b_q);
      end
      OP_CVT: side_d.res = (cfg_i.len == cfg_i.nlen) ? a64 : requant(a64, cfg_i);
      default: side_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (ce_i) begin
      valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      side_o <= side_d;
      div_o  <= div_d;
    end
  end

endmodule

@@ hw/rtl/fpa_div.sv @@
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage. The execute-stage
// results travel alongside so every operation leaves in order.
// ----------------------------------------------------------------------------
module fpa_div import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  ce_i,
  input  logic  valid_i,
  input  side_t side_i,
  input  div_t  div_i,
  output logic  valid_o,
  output side_t side_o,
  output div_t  div_o
);

  logic  valid_q [QBITS];
  side_t side_q  [QBITS];
  div_t  div_q   [QBITS];

  function automatic div_t step(input div_t x);
    div_t            y;
    logic [WORD_WIDTH:0] t, dif;
    logic            ge;
    t    = {x.rem, x.nq[QBITS-1]};
    dif  = t - {1'b0, x.dvs};
    ge   = !dif[WORD_WIDTH];
    y    = x;
    y.rem = ge ? dif[WORD_WIDTH-1:0] : t[WORD_WIDTH-1:0];
    y.nq  = {x.nq[QBITS-2:0], ge};
    return y;
  endfunction

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ce_i) begin
        valid_q[k] <= (k == 0) ? valid_i : valid_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        if (k == 0) begin
          side_q[k] <= side_i;
          div_q[k]  <= step(div_i);
        end else begin
          side_q[k] <= side_q[(k == 0) ? 0 : k-1];
          div_q[k]  <= step(div_q[(k == 0) ? 0 : k-1]);
        end
      end
    end
  end

  assign valid_o = valid_q[QBITS-1];
  assign side_o  = side_q[QBITS-1];
  assign div_o   = div_q[QBITS-1];

endmodule
